// ===== rtl/dxt_block_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Concurrent assertion shorthands, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_UNIT_MACROS_SVH
`define DXT_BLOCK_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DXT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dxt assertion failed");
// next-cycle implication
`define DXT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dxt assertion failed");
`else
`define DXT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DXT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT decoder package
// Format codes, register indexes, job type, back-end states, divide helpers.
// ----------------------------------------------------------------------------
package dxt_pkg;

  localparam logic [2:0] FMT_DXT1 = 3'd0;
  localparam logic [2:0] FMT_DXT2 = 3'd1;
  localparam logic [2:0] FMT_DXT3 = 3'd2;
  localparam logic [2:0] FMT_DXT4 = 3'd3;
  localparam logic [2:0] FMT_DXT5 = 3'd4;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [63:0] color;
    logic [63:0] alpha;
    logic [2:0]  fmt;
    logic [13:0] px;
    logic [13:0] py;
    logic [2:0]  ncols;
    logic [2:0]  nrows;
    logic        final_blk;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXPAND,
    BK_MIX,
    BK_TEXEL,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  // c*255/31 via reciprocal
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [26:0] prod;
    prod = 27'(c) * 27'(2156535);
    return prod[25:18];
  endfunction

  // c*255/63 via reciprocal
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [28:0] prod;
    prod = 29'(c) * 29'(4244475);
    return prod[27:20];
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'(683);
    return prod[18:11];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] prod;
    prod = 23'(x) * 23'(2341);
    return prod[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] prod;
    prod = 23'(x) * 23'(3277);
    return prod[21:14];
  endfunction

endpackage

// ===== rtl/dxt_front.sv =====
// ----------------------------------------------------------------------------
// DXT front end
// Accepts block words, holds the alpha half, tracks block position, builds jobs.
// ----------------------------------------------------------------------------
module dxt_front #(
  parameter int MAX_DIM = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        block_word_i,
  input  logic [2:0]         fmt_i,
  input  logic [14:0]        width_i,
  input  logic [14:0]        height_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output dxt_pkg::job_t      job_o
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = DW - 1;
  localparam int PW = DW + 1;
  localparam int EW = ((DW > 15) ? DW : 15) + 1;

  logic [63:0]   alpha_q;
  logic          awaiting_q, awaiting_d;
  logic [CW-1:0] col_q, col_d, row_q, row_d;

  logic [2:0]    fmt;
  logic [EW-1:0] wx, hx;
  logic [DW-1:0] w, h;
  logic          wrap_c, wrap_r, wrap_c2, wrap_r2;
  logic [CW-1:0] col_n, row_t, row_n, col_inc, row_inc;
  logic [PW-1:0] bx, by, remw, remh;
  logic          accept, is_alpha;

  assign fmt = (fmt_i > dxt_pkg::FMT_DXT5) ? dxt_pkg::FMT_DXT1 : fmt_i;

  // saturate dimensions to 1..MAX_DIM
  assign wx = EW'(width_i);
  assign hx = EW'(height_i);
  assign w  = (wx == '0) ? DW'(1) : ((wx > EW'(MAX_DIM)) ? DW'(MAX_DIM) : wx[DW-1:0]);
  assign h  = (hx == '0) ? DW'(1) : ((hx > EW'(MAX_DIM)) ? DW'(MAX_DIM) : hx[DW-1:0]);

  // pull a position back inside the image
  assign wrap_c = {col_q, 2'b00} >= PW'(w);
  assign col_n  = wrap_c ? '0 : col_q;
  assign row_t  = wrap_c ? row_q + CW'(1) : row_q;
  assign wrap_r = {row_t, 2'b00} >= PW'(h);
  assign row_n  = wrap_r ? '0 : row_t;

  assign bx   = {col_n, 2'b00};
  assign by   = {row_n, 2'b00};
  assign remw = PW'(w) - bx;
  assign remh = PW'(h) - by;

  // advance in raster order
  assign col_inc = col_n + CW'(1);
  assign row_inc = row_n + CW'(1);
  assign wrap_c2 = {col_inc, 2'b00} >= PW'(w);
  assign wrap_r2 = {row_inc, 2'b00} >= PW'(h);

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_alpha   = (fmt != dxt_pkg::FMT_DXT1) && !awaiting_q;
  assign push_o     = accept && !is_alpha;

  always_comb begin
    awaiting_d = awaiting_q;
    col_d      = col_q;
    row_d      = row_q;
    if (accept) begin
      if (is_alpha) begin
        awaiting_d = 1'b1;
      end else begin
        awaiting_d = 1'b0;
        if (wrap_c2) begin
          col_d = '0;
          row_d = wrap_r2 ? '0 : row_inc;
        end else begin
          col_d = col_inc;
          row_d = row_n;
        end
      end
    end
  end

  always_comb begin
    job_o.color     = block_word_i;
    job_o.alpha     = alpha_q;
    job_o.fmt       = fmt;
    job_o.px        = bx[13:0];
    job_o.py        = by[13:0];
    job_o.ncols     = (remw >= PW'(4)) ? 3'd4 : remw[2:0];
    job_o.nrows     = (remh >= PW'(4)) ? 3'd4 : remh[2:0];
    job_o.final_blk = (remw <= PW'(4)) && (remh <= PW'(4));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_alpha) begin
      alpha_q <= block_word_i;
    end
  end

endmodule

// ===== rtl/dxt_queue.sv =====
// ----------------------------------------------------------------------------
// DXT job queue
// Two-entry FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module dxt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dxt_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dxt_pkg::job_t job_o
);

  dxt_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== rtl/dxt_back.sv =====
// ----------------------------------------------------------------------------
// DXT back end
// Builds palettes for one block and emits its texels, undoing premultiply.
// ----------------------------------------------------------------------------
module dxt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  dxt_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [13:0]   pixel_x_o,
  output logic [13:0]   pixel_y_o,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [7:0]    alpha_o,
  output logic          last_of_block_o,
  output logic          last_of_image_o
);

  dxt_pkg::back_state_e state_q, state_d;
  dxt_pkg::job_t        job_q;

  logic [7:0] e0_q [3];
  logic [7:0] e1_q [3];
  logic       cut_q;
  logic [7:0] pal_q [4][3];
  logic [7:0] apal_q [8];
  logic [1:0] x_q, y_q;
  logic [2:0] cnt_q;

  logic [7:0] rem_q [3];
  logic [7:0] lo_q  [3];
  logic [7:0] quo_q [3];
  logic [2:0] sat_q, zero_q;

  logic [13:0] px_q, py_q;
  logic [7:0]  rgb_q [3];
  logic [7:0]  a_q;
  logic        lblk_q, limg_q;

  logic [3:0]  t;
  logic [31:0] sel;
  logic [1:0]  ci;
  logic [5:0]  aidx;
  logic [7:0]  tex_a;
  logic        premul, last_tex, div_done;
  logic [7:0]  a0, a1;
  logic [8:0]  r_try [3];
  logic        qbit [3];
  logic [7:0]  quo_nx [3];

  assign t        = {y_q, x_q};
  assign sel      = job_q.color[63:32];
  assign ci       = sel[{t, 1'b0} +: 2];
  assign aidx     = 6'd16 + 6'(t) * 6'd3;
  assign premul   = (job_q.fmt == dxt_pkg::FMT_DXT2) || (job_q.fmt == dxt_pkg::FMT_DXT4);
  assign last_tex = (({1'b0, x_q} + 3'd1) == job_q.ncols) &&
                    (({1'b0, y_q} + 3'd1) == job_q.nrows);
  assign div_done = (cnt_q == 3'd7);
  assign a0       = job_q.alpha[7:0];
  assign a1       = job_q.alpha[15:8];

  always_comb begin
    tex_a = ((ci == 2'd3) && cut_q) ? 8'd0 : 8'd255;
    if ((job_q.fmt == dxt_pkg::FMT_DXT2) || (job_q.fmt == dxt_pkg::FMT_DXT3)) begin
      tex_a = {2{job_q.alpha[{t, 2'b00} +: 4]}};
    end else if ((job_q.fmt == dxt_pkg::FMT_DXT4) || (job_q.fmt == dxt_pkg::FMT_DXT5)) begin
      tex_a = apal_q[job_q.alpha[aidx +: 3]];
    end
  end

  // one restoring step per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_try[k]  = {rem_q[k], lo_q[k][7]};
      qbit[k]   = r_try[k] >= {1'b0, a_q};
      quo_nx[k] = {quo_q[k][6:0], qbit[k]};
    end
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      dxt_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = dxt_pkg::BK_EXPAND;
        end
      end
      dxt_pkg::BK_EXPAND: state_d = dxt_pkg::BK_MIX;
      dxt_pkg::BK_MIX:    state_d = dxt_pkg::BK_TEXEL;
      dxt_pkg::BK_TEXEL:  state_d = premul ? dxt_pkg::BK_DIV : dxt_pkg::BK_EMIT;
      dxt_pkg::BK_DIV: begin
        if (div_done) state_d = dxt_pkg::BK_EMIT;
      end
      dxt_pkg::BK_EMIT: begin
        if (!out_stall_i) begin
          state_d = last_tex ? dxt_pkg::BK_IDLE : dxt_pkg::BK_TEXEL;
        end
      end
      default: state_d = dxt_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dxt_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dxt_pkg::BK_IDLE: begin
        job_q <= job_i;
      end
      dxt_pkg::BK_EXPAND: begin
        e0_q[0] <= dxt_pkg::expand5(job_q.color[15:11]);
        e0_q[1] <= dxt_pkg::expand6(job_q.color[10:5]);
        e0_q[2] <= dxt_pkg::expand5(job_q.color[4:0]);
        e1_q[0] <= dxt_pkg::expand5(job_q.color[31:27]);
        e1_q[1] <= dxt_pkg::expand6(job_q.color[26:21]);
        e1_q[2] <= dxt_pkg::expand5(job_q.color[20:16]);
        cut_q   <= (job_q.fmt == dxt_pkg::FMT_DXT1) &&
                   (job_q.color[15:0] <= job_q.color[31:16]);
        x_q     <= 2'd0;
        y_q     <= 2'd0;
      end
      dxt_pkg::BK_MIX: begin
        for (int k = 0; k < 3; k++) begin
          pal_q[0][k] <= e0_q[k];
          pal_q[1][k] <= e1_q[k];
          if (cut_q) begin
            pal_q[2][k] <= 8'((9'(e0_q[k]) + 9'(e1_q[k])) >> 1);
            pal_q[3][k] <= 8'd0;
          end else begin
            pal_q[2][k] <= dxt_pkg::div3({e0_q[k], 1'b0} + 10'(e1_q[k]));
            pal_q[3][k] <= dxt_pkg::div3(10'(e0_q[k]) + {e1_q[k], 1'b0});
          end
        end
        apal_q[0] <= a0;
        apal_q[1] <= a1;
        if (a0 > a1) begin
          for (int i = 1; i <= 6; i++) begin
            apal_q[i+1] <= dxt_pkg::div7(11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1));
          end
        end else begin
          for (int i = 1; i <= 4; i++) begin
            apal_q[i+1] <= dxt_pkg::div5(11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1));
          end
          apal_q[6] <= 8'd0;
          apal_q[7] <= 8'd255;
        end
      end
      dxt_pkg::BK_TEXEL: begin
        px_q   <= job_q.px + 14'(x_q);
        py_q   <= job_q.py + 14'(y_q);
        a_q    <= tex_a;
        lblk_q <= last_tex;
        limg_q <= last_tex && job_q.final_blk;
        cnt_q  <= 3'd0;
        for (int k = 0; k < 3; k++) begin
          // dividend c*255 + a/2, top byte seeds the remainder
          logic [15:0] num;
          num       = {pal_q[ci][k], 8'd0} - 16'(pal_q[ci][k]) + 16'(tex_a >> 1);
          rgb_q[k]  <= pal_q[ci][k];
          rem_q[k]  <= num[15:8];
          lo_q[k]   <= num[7:0];
          quo_q[k]  <= 8'd0;
          sat_q[k]  <= pal_q[ci][k] >= tex_a;
          zero_q[k] <= (tex_a == 8'd0);
        end
      end
      dxt_pkg::BK_DIV: begin
        cnt_q <= cnt_q + 3'd1;
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= qbit[k] ? 8'(r_try[k] - {1'b0, a_q}) : r_try[k][7:0];
          lo_q[k]  <= {lo_q[k][6:0], 1'b0};
          quo_q[k] <= quo_nx[k];
          if (div_done) begin
            rgb_q[k] <= zero_q[k] ? 8'd0 : (sat_q[k] ? 8'd255 : quo_nx[k]);
          end
        end
      end
      dxt_pkg::BK_EMIT: begin
        if (!out_stall_i) begin
          if (x_q == 2'(job_q.ncols - 3'd1)) begin
            x_q <= 2'd0;
            y_q <= y_q + 2'd1;
          end else begin
            x_q <= x_q + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = (state_q == dxt_pkg::BK_EMIT);
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign red_o           = rgb_q[0];
  assign green_o         = rgb_q[1];
  assign blue_o          = rgb_q[2];
  assign alpha_o         = a_q;
  assign last_of_block_o = lblk_q;
  assign last_of_image_o = limg_q;

endmodule

// ===== rtl/dxt_block_decoder_unit.sv =====
// An accepted color word becomes a job in the queue; the back-end sequencer pops it,
// builds the palettes in EXPAND and MIX once per block, then gives each texel in TEXEL
// and EMIT (DXT2/DXT4 texels first pass the 8-step divider in DIV). EMIT holds while
// out_stall_i is high; the next job is popped only after the block's last texel.
// Alpha words of DXT2..DXT5 are held in the front end and give no texel.
// Reset (rst_ni low, async) clears the block position, the alpha flag, the queue and
// the registers to DXT1, 4 x 4 pixels.
// ----------------------------------------------------------------------------
// DXT block decoder unit
// BC1/BC2/BC3 texture block decoder: front end, job queue, texel back end.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_unit_macros.svh"

module dxt_block_decoder_unit #(
  parameter int MAX_DIM = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // block word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_word_i,
  // texel channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] pixel_x_o,
  output logic [13:0] pixel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_of_block_o,
  output logic        last_of_image_o
);

  logic [2:0]    format_q;
  logic [14:0]   width_q, height_q;
  logic          cfg_wr;

  logic          q_push, q_full, q_pop, q_valid;
  dxt_pkg::job_t job_front, job_back;

  // Register file: written at the access phase of a write transaction.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= dxt_pkg::FMT_DXT1;
      width_q  <= 15'd4;
      height_q <= 15'd4;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dxt_pkg::REG_FORMAT: format_q <= pwdata[2:0];
        dxt_pkg::REG_WIDTH:  width_q  <= pwdata[14:0];
        dxt_pkg::REG_HEIGHT: height_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dxt_pkg::REG_FORMAT: prdata = 32'(format_q);
      dxt_pkg::REG_WIDTH:  prdata = 32'(width_q);
      dxt_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:             prdata = 32'd0;
    endcase
  end

  // Front: hold the alpha half, place the block, hand a job to the queue.
  dxt_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .block_word_i (block_word_i),
    .fmt_i        (format_q),
    .width_i      (width_q),
    .height_i     (height_q),
    .queue_full_i (q_full),
    .push_o       (q_push),
    .job_o        (job_front)
  );

  // Two jobs of slack so the front keeps taking words while texels drain.
  dxt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_front),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (job_back)
  );

  // Back: expand palettes, then walk texels in raster order within the block.
  dxt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .job_i           (job_back),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_of_block_o (last_of_block_o),
    .last_of_image_o (last_of_image_o)
  );

  // never push into a full queue
  `DXT_ASSERT_IMP(a_queue_no_overflow, clk_i, rst_ni, q_push, !q_full)
  // end of image only on the final texel of a block
  `DXT_ASSERT_IMP(a_image_end_on_block_end, clk_i, rst_ni, out_valid_o && last_of_image_o, last_of_block_o)
  // a freshly popped job needs palette setup before any texel shows
  `DXT_ASSERT_NXT(a_pop_then_setup, clk_i, rst_ni, q_pop, !out_valid_o)

endmodule
